### rtl/core/fbik_pkg.sv
package fbik_pkg;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_HALF_SPAN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CRANK_LENGTH   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COUPLER_LENGTH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_MID_X     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_MID_Y     = 3'd4;

	// fixed datapath widths after normalization
	localparam int SC_W   = 30;  // scaled link terms
	localparam int DEF_W  = 62;  // d, e, f at first scale
	localparam int RS_W   = 31;  // d, e, f at second scale
	localparam int DISC_W = 62;  // discriminant magnitude
	localparam int ROOT_W = 31;  // floor square root
	localparam int CORD_W = 36;  // cordic x/y
	localparam int Z_W    = 34;  // cordic angle, q30
	localparam int COS_W  = 35;  // cos/sin after product

	localparam int TABLE_LEN = 24;
	localparam logic [29:0] ATAN_Q30 [0:TABLE_LEN-1] = '{
		30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
		30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
		30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
		30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255, 30'd127
	};

	localparam logic signed [CORD_W-1:0] KINV_Q30 = 36'sd652032874;
	localparam longint PI_Q30 = 64'sd3373259426;

	typedef struct packed {
		logic                   ok;
		logic signed [RS_W-1:0] d;
		logic signed [RS_W-1:0] e;
	} sq_carry_t;

endpackage

### rtl/core/fbik_side.sv
module fbik_side #(
	parameter int DATA_WIDTH    = 32,
	parameter int FRAC_BITS     = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          valid_in,
	input  logic signed [DATA_WIDTH+1:0]  u,
	input  logic signed [DATA_WIDTH-1:0]  y,
	input  logic        [DATA_WIDTH-2:0]  l1,
	input  logic        [DATA_WIDTH-2:0]  l2,
	input  logic signed [DATA_WIDTH:0]    pivot_x,
	input  logic signed [DATA_WIDTH-1:0]  mid_y,
	output logic                          valid_out,
	output logic                          ok,
	output logic signed [FRAC_BITS+2:0]   angle,
	output logic signed [DATA_WIDTH-1:0]  elbow_x,
	output logic signed [DATA_WIDTH-1:0]  elbow_y
);
	import fbik_pkg::*;

	localparam int PW  = DATA_WIDTH + 2;
	localparam int SW  = $clog2(PW + 1);
	localparam int RW  = $clog2(DEF_W + 1);
	localparam int NS  = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
	localparam int AW  = FRAC_BITS + 3;
	localparam int AS  = 30 - FRAC_BITS;
	localparam int CS  = (DATA_WIDTH > 32) ? DATA_WIDTH - 32 : 0;
	localparam int PRW = DATA_WIDTH + COS_W;
	localparam int LAT = 9 + ROOT_W + 2 * (NS + 1) + 4;
	localparam longint LIM = (PI_Q30 + (64'sd1 <<< (AS - 1))) >>> AS;
	localparam logic signed [Z_W+1:0] LIM_A = (Z_W + 2)'(LIM);
	localparam logic signed [Z_W+1:0] AHALF = (Z_W + 2)'(1) <<< (AS - 1);
	localparam logic signed [PRW:0] RND = (PRW + 1)'(1) <<< (29 - CS);

	function automatic logic [PW-1:0] mag_pw(input logic signed [PW-1:0] v);
		return v[PW-1] ? PW'(-v) : PW'(v);
	endfunction

	function automatic logic [DEF_W-1:0] mag_def(input logic signed [DEF_W-1:0] v);
		return v[DEF_W-1] ? DEF_W'(-v) : DEF_W'(v);
	endfunction

	function automatic logic [SW-1:0] pre_shift(input logic [PW-1:0] m);
		int bl;
		bl = 0;
		for (int i = 0; i < PW; i++) if (m[i]) bl = i + 1;
		return (bl > 29) ? SW'(bl - 29) : '0;
	endfunction

	function automatic logic [RW-1:0] post_shift(input logic [DEF_W-1:0] m);
		int bl;
		bl = 0;
		for (int i = 0; i < DEF_W; i++) if (m[i]) bl = i + 1;
		return (bl > 30) ? RW'(bl - 30) : '0;
	endfunction

	function automatic logic [DATA_WIDTH-1:0] sat_dw(input logic signed [PRW+1:0] v);
		if (v > $signed({{(PRW+3-DATA_WIDTH){1'b0}}, {(DATA_WIDTH-1){1'b1}}}))
			return {1'b0, {(DATA_WIDTH-1){1'b1}}};
		if (v < $signed({{(PRW+3-DATA_WIDTH){1'b1}}, {(DATA_WIDTH-1){1'b0}}}))
			return {1'b1, {(DATA_WIDTH-1){1'b0}}};
		return v[DATA_WIDTH-1:0];
	endfunction

	// valid travels alongside the data
	logic [LAT-1:0] vld_s;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-2:0], valid_in};
		end
	end
	assign valid_out = vld_s[LAT-1];

	// s1: link sums
	logic signed [PW-1:0] l1_x;
	logic signed [PW-1:0] p_s1, q_s1, y_s1, l1_s1, l2_s1;
	assign l1_x = $signed({3'b000, l1});

	// s2: largest magnitude
	logic [PW-1:0] m_s2, m_c;
	logic signed [PW-1:0] p_s2, q_s2, y_s2, l1_s2, l2_s2;
	always_comb begin
		m_c = mag_pw(p_s1);
		if (mag_pw(q_s1) > m_c) m_c = mag_pw(q_s1);
		if (mag_pw(y_s1) > m_c) m_c = mag_pw(y_s1);
		if (mag_pw(l1_s1) > m_c) m_c = mag_pw(l1_s1);
		if (mag_pw(l2_s1) > m_c) m_c = mag_pw(l2_s1);
	end

	// s3: scale below 2^29
	logic [SW-1:0] sh_c;
	logic signed [PW-1:0] p_sh, q_sh, y_sh, l1_sh, l2_sh;
	logic signed [SC_W-1:0] p_s3, q_s3, y_s3, l1_s3, l2_s3;
	always_comb begin
		sh_c  = pre_shift(m_s2);
		p_sh  = p_s2 >>> sh_c;
		q_sh  = q_s2 >>> sh_c;
		y_sh  = y_s2 >>> sh_c;
		l1_sh = l1_s2 >>> sh_c;
		l2_sh = l2_s2 >>> sh_c;
	end

	// s4: squares and the y*l1 product
	logic signed [2*SC_W-1:0] pp_s4, qq_s4, yy_s4, ll_s4, yl_s4;

	// s5: d, e, f
	logic signed [DEF_W-1:0] d_c, e_c, f_c;
	logic signed [DEF_W-1:0] d_s5, e_s5, f_s5;
	logic dz_s5;
	always_comb begin
		d_c = $signed({{2{pp_s4[2*SC_W-1]}}, pp_s4}) + $signed({{2{yy_s4[2*SC_W-1]}}, yy_s4})
			- $signed({{2{ll_s4[2*SC_W-1]}}, ll_s4});
		f_c = $signed({{2{qq_s4[2*SC_W-1]}}, qq_s4}) + $signed({{2{yy_s4[2*SC_W-1]}}, yy_s4})
			- $signed({{2{ll_s4[2*SC_W-1]}}, ll_s4});
		e_c = $signed({yl_s4[2*SC_W-1], yl_s4, 1'b0});
	end

	// s6: largest of d, e, f
	logic [DEF_W-1:0] big_c, big_s6;
	logic signed [DEF_W-1:0] d_s6, e_s6, f_s6;
	logic dz_s6;
	always_comb begin
		big_c = mag_def(d_s5);
		if (mag_def(e_s5) > big_c) big_c = mag_def(e_s5);
		if (mag_def(f_s5) > big_c) big_c = mag_def(f_s5);
	end

	// s7: scale below 2^30
	logic [RW-1:0] r_c;
	logic signed [DEF_W-1:0] d_sh, e_sh, f_sh;
	logic signed [RS_W-1:0] d_s7, e_s7, f_s7;
	logic ok_s7;
	always_comb begin
		r_c  = post_shift(big_s6);
		d_sh = d_s6 >>> r_c;
		e_sh = e_s6 >>> r_c;
		f_sh = f_s6 >>> r_c;
	end

	// s8: discriminant products
	logic signed [2*RS_W-1:0] ee_s8, df_s8;
	logic signed [RS_W-1:0] d_s8, e_s8;
	logic ok_s8;

	// s9 feeds the square root pipe
	logic signed [2*RS_W:0] disc_c;
	assign disc_c = $signed({ee_s8[2*RS_W-1], ee_s8}) - $signed({df_s8[2*RS_W-1], df_s8});

	logic [DISC_W-1:0] sq_rem_s [0:ROOT_W];
	logic [ROOT_W-1:0] sq_root_s [0:ROOT_W];
	sq_carry_t         sq_c_s [0:ROOT_W];

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1  <= l1_x + u;
			q_s1  <= l1_x - u;
			y_s1  <= $signed({{2{y[DATA_WIDTH-1]}}, y});
			l1_s1 <= l1_x;
			l2_s1 <= $signed({3'b000, l2});

			m_s2  <= m_c;
			p_s2  <= p_s1;
			q_s2  <= q_s1;
			y_s2  <= y_s1;
			l1_s2 <= l1_s1;
			l2_s2 <= l2_s1;

			p_s3  <= p_sh[SC_W-1:0];
			q_s3  <= q_sh[SC_W-1:0];
			y_s3  <= y_sh[SC_W-1:0];
			l1_s3 <= l1_sh[SC_W-1:0];
			l2_s3 <= l2_sh[SC_W-1:0];

			pp_s4 <= p_s3 * p_s3;
			qq_s4 <= q_s3 * q_s3;
			yy_s4 <= y_s3 * y_s3;
			ll_s4 <= l2_s3 * l2_s3;
			yl_s4 <= y_s3 * l1_s3;

			d_s5  <= d_c;
			e_s5  <= e_c;
			f_s5  <= f_c;
			dz_s5 <= (d_c == '0);

			big_s6 <= big_c;
			d_s6   <= d_s5;
			e_s6   <= e_s5;
			f_s6   <= f_s5;
			dz_s6  <= dz_s5;

			d_s7  <= d_sh[RS_W-1:0];
			e_s7  <= e_sh[RS_W-1:0];
			f_s7  <= f_sh[RS_W-1:0];
			ok_s7 <= !dz_s6;

			ee_s8 <= e_s7 * e_s7;
			df_s8 <= d_s7 * f_s7;
			d_s8  <= d_s7;
			e_s8  <= e_s7;
			ok_s8 <= ok_s7;

			sq_rem_s[0]  <= disc_c[DISC_W-1:0];
			sq_root_s[0] <= '0;
			sq_c_s[0]    <= '{ok: ok_s8 && !disc_c[2*RS_W], d: d_s8, e: e_s8};
		end
	end

	// one root bit per stage
	for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
		localparam int B = ROOT_W - 1 - k;
		logic [63:0] trial;
		assign trial = ({{(64-ROOT_W){1'b0}}, sq_root_s[k]} << (B + 1)) + (64'd1 << (2 * B));
		always_ff @(posedge clk) begin
			if (en) begin
				sq_c_s[k+1] <= sq_c_s[k];
				if ({2'b00, sq_rem_s[k]} >= trial) begin
					sq_rem_s[k+1]  <= sq_rem_s[k] - trial[DISC_W-1:0];
					sq_root_s[k+1] <= sq_root_s[k] | (ROOT_W'(1) << B);
				end else begin
					sq_rem_s[k+1]  <= sq_rem_s[k];
					sq_root_s[k+1] <= sq_root_s[k];
				end
			end
		end
	end

	// vectoring cordic, den in x and num in y
	logic signed [CORD_W-1:0] vx_s [0:NS];
	logic signed [CORD_W-1:0] vy_s [0:NS];
	logic signed [Z_W-1:0]    vz_s [0:NS];
	logic                     vok_s [0:NS];
	logic signed [CORD_W-1:0] den_c, num_c;
	sq_carry_t sc_end;

	always_comb begin
		sc_end = sq_c_s[ROOT_W];
		den_c  = $signed({{(CORD_W-RS_W){sc_end.d[RS_W-1]}}, sc_end.d});
		num_c  = $signed({{(CORD_W-RS_W){sc_end.e[RS_W-1]}}, sc_end.e})
			+ $signed({{(CORD_W-ROOT_W){1'b0}}, sq_root_s[ROOT_W]});
		if (sc_end.d[RS_W-1]) begin
			den_c = -den_c;
			num_c = -num_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vx_s[0]  <= den_c;
			vy_s[0]  <= num_c;
			vz_s[0]  <= '0;
			vok_s[0] <= sc_end.ok;
		end
	end

	for (genvar i = 0; i < NS; i++) begin : g_vec
		logic signed [Z_W-1:0] at;
		assign at = $signed({{(Z_W-30){1'b0}}, ATAN_Q30[i]});
		always_ff @(posedge clk) begin
			if (en) begin
				vok_s[i+1] <= vok_s[i];
				if (!vy_s[i][CORD_W-1]) begin
					vx_s[i+1] <= vx_s[i] + (vy_s[i] >>> i);
					vy_s[i+1] <= vy_s[i] - (vx_s[i] >>> i);
					vz_s[i+1] <= vz_s[i] + at;
				end else begin
					vx_s[i+1] <= vx_s[i] - (vy_s[i] >>> i);
					vy_s[i+1] <= vy_s[i] + (vx_s[i] >>> i);
					vz_s[i+1] <= vz_s[i] - at;
				end
			end
		end
	end

	// rotation cordic of phi for cos/sin of the half angle
	logic signed [CORD_W-1:0] rx_s [0:NS];
	logic signed [CORD_W-1:0] ry_s [0:NS];
	logic signed [Z_W-1:0]    rz_s [0:NS];
	logic signed [Z_W-1:0]    rphi_s [0:NS];
	logic                     rok_s [0:NS];

	always_ff @(posedge clk) begin
		if (en) begin
			rx_s[0]   <= KINV_Q30;
			ry_s[0]   <= '0;
			rz_s[0]   <= vz_s[NS];
			rphi_s[0] <= vz_s[NS];
			rok_s[0]  <= vok_s[NS];
		end
	end

	for (genvar i = 0; i < NS; i++) begin : g_rot
		logic signed [Z_W-1:0] at;
		assign at = $signed({{(Z_W-30){1'b0}}, ATAN_Q30[i]});
		always_ff @(posedge clk) begin
			if (en) begin
				rok_s[i+1]  <= rok_s[i];
				rphi_s[i+1] <= rphi_s[i];
				if (!rz_s[i][Z_W-1]) begin
					rx_s[i+1] <= rx_s[i] - (ry_s[i] >>> i);
					ry_s[i+1] <= ry_s[i] + (rx_s[i] >>> i);
					rz_s[i+1] <= rz_s[i] - at;
				end else begin
					rx_s[i+1] <= rx_s[i] + (ry_s[i] >>> i);
					ry_s[i+1] <= ry_s[i] - (rx_s[i] >>> i);
					rz_s[i+1] <= rz_s[i] + at;
				end
			end
		end
	end

	// tail: double-angle products, crank offsets, angle, saturation
	logic signed [31:0] c_c, s_c;
	logic signed [63:0] cc_s10, ss_s10, cs_s10;
	logic signed [Z_W-1:0] phi_s10, phi_s11;
	logic ok_s10, ok_s11, ok_s12, ok_s13;
	logic signed [64:0] cdiff_c, scs_c;
	logic signed [COS_W-1:0] cos_s11, sin_s11;
	logic signed [PRW-1:0] prx_s12, pry_s12;
	logic signed [Z_W+1:0] a_c, ang_c;
	logic signed [AW-1:0] ang_s12, ang_s13;
	logic signed [PRW:0] offx_c, offy_c;
	logic signed [PRW+1:0] sumx_c, sumy_c;
	logic signed [DATA_WIDTH-1:0] ex_s13, ey_s13;

	assign c_c = rx_s[NS][31:0];
	assign s_c = ry_s[NS][31:0];

	always_comb begin
		cdiff_c = $signed({cc_s10[63], cc_s10}) - $signed({ss_s10[63], ss_s10});
		cdiff_c = cdiff_c >>> (30 + CS);
		scs_c   = $signed({cs_s10, 1'b0}) >>> (30 + CS);

		a_c = ($signed({phi_s11[Z_W-1], phi_s11, 1'b0}) + AHALF) >>> AS;
		if (a_c > LIM_A) ang_c = LIM_A;
		else if (a_c < -LIM_A) ang_c = -LIM_A;
		else ang_c = a_c;

		offx_c = ($signed({prx_s12[PRW-1], prx_s12}) + RND) >>> (30 - CS);
		offy_c = ($signed({pry_s12[PRW-1], pry_s12}) + RND) >>> (30 - CS);
		sumx_c = $signed({{(PRW+1-DATA_WIDTH){pivot_x[DATA_WIDTH]}}, pivot_x})
			+ $signed({offx_c[PRW], offx_c});
		sumy_c = $signed({{(PRW+2-DATA_WIDTH){mid_y[DATA_WIDTH-1]}}, mid_y})
			+ $signed({offy_c[PRW], offy_c});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cc_s10  <= c_c * c_c;
			ss_s10  <= s_c * s_c;
			cs_s10  <= c_c * s_c;
			phi_s10 <= rphi_s[NS];
			ok_s10  <= rok_s[NS];

			cos_s11 <= cdiff_c[COS_W-1:0];
			sin_s11 <= scs_c[COS_W-1:0];
			phi_s11 <= phi_s10;
			ok_s11  <= ok_s10;

			prx_s12 <= $signed({1'b0, l1}) * cos_s11;
			pry_s12 <= $signed({1'b0, l1}) * sin_s11;
			ang_s12 <= ang_c[AW-1:0];
			ok_s12  <= ok_s11;

			ex_s13  <= sat_dw(sumx_c);
			ey_s13  <= sat_dw(sumy_c);
			ang_s13 <= ang_s12;
			ok_s13  <= ok_s12;
		end
	end

	assign ok      = ok_s13;
	assign angle   = ang_s13;
	assign elbow_x = ex_s13;
	assign elbow_y = ey_s13;

endmodule

### rtl/core/five_bar_inverse_kinematics.sv
// channel   direction  handshake            payload
// cfg       in         cfg_write            cfg_index, cfg_data
// target    in         in_valid / in_stall  target_x, target_y
// solution  out        out_valid / out_stall  angles, elbows, reachable
//
// one request enters per cycle unless the pipe is stalled; the depth is set by the
// 31-stage square root and the two cordic pipes
// reset clears valid bits and config registers; no clearing pass
// a stalled result freezes the whole pipe, so in_stall is high when out_valid and out_stall are both high
module five_bar_inverse_kinematics #(
	parameter int DATA_WIDTH    = 32,
	parameter int FRAC_BITS     = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [fbik_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_WIDTH-1:0]          cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [DATA_WIDTH-1:0]   target_x,
	input  logic signed [DATA_WIDTH-1:0]   target_y,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [FRAC_BITS+2:0]    left_angle,
	output logic signed [FRAC_BITS+2:0]    right_angle,
	output logic signed [DATA_WIDTH-1:0]   left_elbow_x,
	output logic signed [DATA_WIDTH-1:0]   left_elbow_y,
	output logic signed [DATA_WIDTH-1:0]   right_elbow_x,
	output logic signed [DATA_WIDTH-1:0]   right_elbow_y,
	output logic                           reachable
);
	import fbik_pkg::*;

	// configuration registers
	logic [DATA_WIDTH-2:0]        half_span_q, crank_q, coupler_q;
	logic signed [DATA_WIDTH-1:0] mid_x_q, mid_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_span_q <= '0;
			crank_q     <= '0;
			coupler_q   <= '0;
			mid_x_q     <= '0;
			mid_y_q     <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_BASE_HALF_SPAN: half_span_q <= cfg_data[DATA_WIDTH-2:0];
				REG_CRANK_LENGTH:   crank_q     <= cfg_data[DATA_WIDTH-2:0];
				REG_COUPLER_LENGTH: coupler_q   <= cfg_data[DATA_WIDTH-2:0];
				REG_BASE_MID_X:     mid_x_q     <= cfg_data;
				REG_BASE_MID_Y:     mid_y_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// global advance: the pipe moves unless a finished result is held back
	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// target x shifted by the half span for each side, and the x of each crank pivot
	logic signed [DATA_WIDTH+1:0] x_x, h_x, u_left, u_right;
	logic signed [DATA_WIDTH:0]   piv_left, piv_right;
	assign x_x       = $signed({{2{target_x[DATA_WIDTH-1]}}, target_x});
	assign h_x       = $signed({3'b000, half_span_q});
	assign u_left    = x_x + h_x;
	assign u_right   = x_x - h_x;
	assign piv_left  = $signed({mid_x_q[DATA_WIDTH-1], mid_x_q}) - $signed({2'b00, half_span_q});
	assign piv_right = $signed({mid_x_q[DATA_WIDTH-1], mid_x_q}) + $signed({2'b00, half_span_q});

	logic vl, vr, okl, okr;
	logic signed [FRAC_BITS+2:0]  al, ar;
	logic signed [DATA_WIDTH-1:0] lx, ly, rx, ry;

	fbik_side #(
		.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)
	) u_left_side (
		.clk(clk), .arst_n(arst_n), .en(en), .valid_in(in_valid),
		.u(u_left), .y(target_y), .l1(crank_q), .l2(coupler_q),
		.pivot_x(piv_left), .mid_y(mid_y_q),
		.valid_out(vl), .ok(okl), .angle(al), .elbow_x(lx), .elbow_y(ly)
	);

	fbik_side #(
		.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES)
	) u_right_side (
		.clk(clk), .arst_n(arst_n), .en(en), .valid_in(in_valid),
		.u(u_right), .y(target_y), .l1(crank_q), .l2(coupler_q),
		.pivot_x(piv_right), .mid_y(mid_y_q),
		.valid_out(vr), .ok(okr), .angle(ar), .elbow_x(rx), .elbow_y(ry)
	);

	// output register; unreachable points give all zeros
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= vl && vr;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			reachable <= okl && okr;
			if (okl && okr) begin
				left_angle    <= al;
				right_angle   <= ar;
				left_elbow_x  <= lx;
				left_elbow_y  <= ly;
				right_elbow_x <= rx;
				right_elbow_y <= ry;
			end else begin
				left_angle    <= '0;
				right_angle   <= '0;
				left_elbow_x  <= '0;
				left_elbow_y  <= '0;
				right_elbow_x <= '0;
				right_elbow_y <= '0;
			end
		end
	end

endmodule
